FILE: sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/ftaa_pkg.sv
// Shared constants, types and tables of the face-target angular acceleration block.
`timescale 1ns / 1ps
package ftaa_pkg;

    localparam int ANG_PI       = 25736;
    localparam int ANG_TWO_PI   = 51472;
    localparam int ANG_HALF_PI  = 12868;
    localparam int CORDIC_STEPS = 14;
    localparam int CORDIC_XW    = 32;
    localparam int ANG_W        = 17;

    // Divider cell widths: remainder and quotient bits.
    localparam int DIV1_RW = 16;
    localparam int DIV1_NW = 15;
    localparam int DIV2_RW = 17;
    localparam int DIV2_NW = 16;

    typedef logic signed [CORDIC_XW-1:0] t_cxy;
    typedef logic signed [ANG_W-1:0]     t_ang;

    localparam t_ang ATAN_TAB [CORDIC_STEPS] = '{
        17'sd6434, 17'sd3798, 17'sd2007, 17'sd1019, 17'sd511, 17'sd256, 17'sd128,
        17'sd64, 17'sd32, 17'sd16, 17'sd8, 17'sd4, 17'sd2, 17'sd1
    };

    typedef enum logic [1:0] {
        REG_SLOW   = 2'd0,
        REG_TARGET = 2'd1,
        REG_TTT    = 2'd2
    } t_reg_idx;

endpackage

FILE: sv/ftaa_cordic_cell.sv
// One vectoring step of the heading CORDIC, registered.
`timescale 1ns / 1ps
module ftaa_cordic_cell
    import ftaa_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_cxy i_x,
    input  t_cxy i_y,
    input  t_ang i_z,
    output t_cxy o_x,
    output t_cxy o_y,
    output t_ang o_z
);

    t_cxy n_x, n_y;
    t_ang n_z;
    t_cxy r_x, r_y;
    t_ang r_z;

    always_comb begin
        // Rotate toward the x axis; shifts round toward minus infinity.
        if (i_y > 0) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + ATAN_TAB[STEP];
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

FILE: sv/ftaa_div_cell.sv
// One restoring division step: one quotient bit per cell, registered.
`timescale 1ns / 1ps
module ftaa_div_cell
    import ftaa_pkg::*;
#(
    parameter int RW = DIV1_RW,
    parameter int NW = DIV1_NW
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_div,
    input  logic [RW-1:0] i_rem,
    input  logic [NW-1:0] i_num,
    input  logic [NW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [NW-1:0] o_num,
    output logic [NW-1:0] o_quo
);

    logic [RW-1:0] trial;
    logic          ge;
    logic [RW-1:0] r_rem;
    logic [NW-1:0] r_num, r_quo;

    // Remainder stays below the divisor, so its top bit is free for the shift.
    assign trial = {i_rem[RW-2:0], i_num[NW-1]};
    assign ge    = (trial >= i_div);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? (trial - i_div) : trial;
            r_num <= {i_num[NW-2:0], 1'b0};
            r_quo <= {i_quo[NW-2:0], ge};
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

FILE: sv/face_target_angular_accel.sv
// Top level: turn-toward-target steering with bounded rotational acceleration.
//
// Input channel: i_in_valid / o_in_stall with the owner and target positions,
// facing, rotational velocity and maximum acceleration; a transaction takes
// place on a rising edge with valid high and stall low. Output channel:
// o_out_valid / i_out_stall with rot_accel, one result per input transaction.
// The datapath is a row of registered cells: an input stage with the CORDIC
// quadrant turn, 14 CORDIC cells, error wrap, a 15x15 multiply, 15 divider
// cells for the linear ramp, target-rotation and velocity-error stages,
// 16 divider cells for the time constant, and an output register.
// One transaction is taken every cycle while no stalled result holds the row.
// When the receiver stalls with a result waiting, every cell holds, empty
// ones included, and o_in_stall rises in the same cycle; the input is taken
// again in the first cycle the stalled result is not held back.
// Reset clears the valid bits (pipeline empty) and
// loads the register defaults: slow_radius 4096, target_radius 410,
// time_to_target 410. Registers sit on an APB port at byte offsets 0, 4, 8;
// write them only while the pipeline is empty.
`timescale 1ns / 1ps
module face_target_angular_accel
    import ftaa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_owner_x,
    input  logic signed [15:0] i_owner_y,
    input  logic signed [15:0] i_target_x,
    input  logic signed [15:0] i_target_y,
    input  logic signed [15:0] i_facing,
    input  logic signed [15:0] i_rot_velocity,
    input  logic        [14:0] i_max_rot_accel,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_rot_accel,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [3:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready
);

    localparam int LAT = 3 + CORDIC_STEPS + DIV1_NW + 3 + DIV2_NW;

    typedef enum logic [2:0] {
        CLS_ZERO = 3'b001,
        CLS_MAX  = 3'b010,
        CLS_RAMP = 3'b100
    } t_cls;

    typedef struct packed {
        logic               zero;
        logic signed [15:0] facing;
        logic signed [15:0] vel;
        logic        [14:0] maxa;
    } t_cside;

    typedef struct packed {
        logic               neg;
        t_cls               cls;
        logic signed [15:0] vel;
        logic        [14:0] maxa;
    } t_wside;

    typedef struct packed {
        logic        dneg;
        logic        mzero;
        logic        ovf;
        logic [14:0] maxa;
    } t_eside;

    // ---------------- configuration registers ----------------
    logic [14:0] r_slow, r_target;
    logic [15:0] r_ttt;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow   <= 15'd4096;
            r_target <= 15'd410;
            r_ttt    <= 16'd410;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SLOW:   r_slow   <= pwdata[14:0];
                REG_TARGET: r_target <= pwdata[14:0];
                REG_TTT:    r_ttt    <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SLOW:   prdata = {17'd0, r_slow};
            REG_TARGET: prdata = {17'd0, r_target};
            REG_TTT:    prdata = {16'd0, r_ttt};
            default:    prdata = 32'd0;
        endcase
    end

    // ---------------- flow control ----------------
    // The whole row advances together unless a finished result is stalled.
    logic           en;
    logic [LAT-1:0] r_vld;

    assign en          = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // ---------------- input stage: vector and quadrant turn ----------------
    logic signed [16:0] dx, dy;
    logic signed [17:0] ax;
    t_cxy               x_pre, y_pre, n_x0, n_y0;
    t_ang               n_z0;
    t_cxy               r_x0, r_y0;
    t_ang               r_z0;

    assign dx    = 17'(i_target_x) - 17'(i_owner_x);
    assign dy    = 17'(i_target_y) - 17'(i_owner_y);
    assign ax    = -18'(dy);
    assign x_pre = t_cxy'(ax) <<< 12;
    assign y_pre = t_cxy'(dx) <<< 12;

    always_comb begin
        // Move a left half-plane vector to the right half by a quarter turn.
        if (x_pre < 0) begin
            if (y_pre >= 0) begin
                n_x0 = y_pre;
                n_y0 = -x_pre;
                n_z0 = t_ang'(ANG_HALF_PI);
            end else begin
                n_x0 = -y_pre;
                n_y0 = x_pre;
                n_z0 = -t_ang'(ANG_HALF_PI);
            end
        end else begin
            n_x0 = x_pre;
            n_y0 = y_pre;
            n_z0 = '0;
        end
    end

    t_cside r_cs [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0           <= n_x0;
            r_y0           <= n_y0;
            r_z0           <= n_z0;
            r_cs[0].zero   <= (dx == 17'sd0) && (dy == 17'sd0);
            r_cs[0].facing <= i_facing;
            r_cs[0].vel    <= i_rot_velocity;
            r_cs[0].maxa   <= i_max_rot_accel;
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_cs[k+1] <= r_cs[k];
            end
        end
    end

    // ---------------- CORDIC row ----------------
    t_cxy c_x [CORDIC_STEPS+1];
    t_cxy c_y [CORDIC_STEPS+1];
    t_ang c_z [CORDIC_STEPS+1];

    assign c_x[0] = r_x0;
    assign c_y[0] = r_y0;
    assign c_z[0] = r_z0;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        ftaa_cordic_cell #(.STEP(g)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (c_x[g]),
            .i_y   (c_y[g]),
            .i_z   (c_z[g]),
            .o_x   (c_x[g+1]),
            .o_y   (c_y[g+1]),
            .o_z   (c_z[g+1])
        );
    end

    // ---------------- error wrap and classification ----------------
    t_cside             cs_end;
    t_ang               z_fin;
    logic signed [17:0] err;
    logic        [14:0] n_size;
    t_wside             n_ws;

    assign cs_end = r_cs[CORDIC_STEPS];

    always_comb begin
        // Clamp the heading to +-pi; target on owner means heading zero.
        if (cs_end.zero) begin
            z_fin = '0;
        end else if (c_z[CORDIC_STEPS] > t_ang'(ANG_PI)) begin
            z_fin = t_ang'(ANG_PI);
        end else if (c_z[CORDIC_STEPS] < -t_ang'(ANG_PI)) begin
            z_fin = -t_ang'(ANG_PI);
        end else begin
            z_fin = c_z[CORDIC_STEPS];
        end
        err = 18'(z_fin) - 18'(cs_end.facing);
        for (int k = 0; k < 3; k++) begin
            if (err > 18'sd25736) begin
                err = err - 18'(ANG_TWO_PI);
            end else if (err <= -18'sd25736) begin
                err = err + 18'(ANG_TWO_PI);
            end
        end
        n_size      = err[17] ? 15'(-err) : err[14:0];
        n_ws.neg    = err[17];
        n_ws.vel    = cs_end.vel;
        n_ws.maxa   = cs_end.maxa;
        priority if (n_size == 15'd0 || n_size < r_target) begin
            n_ws.cls = CLS_ZERO;
        end else if (n_size > r_slow) begin
            n_ws.cls = CLS_MAX;
        end else begin
            n_ws.cls = CLS_RAMP;
        end
    end

    logic [14:0] r_size;
    t_wside      r_ws;
    logic [29:0] r_prod;
    t_wside      r_ws1 [DIV1_NW+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_size   <= n_size;
            r_ws     <= n_ws;
            r_prod   <= 30'(r_ws.maxa) * 30'(r_size);
            r_ws1[0] <= r_ws;
            for (int k = 0; k < DIV1_NW; k++) begin
                r_ws1[k+1] <= r_ws1[k];
            end
        end
    end

    // ---------------- ramp divider: maxa * size / slow_radius ----------------
    logic [DIV1_RW-1:0] d1_rem [DIV1_NW+1];
    logic [DIV1_NW-1:0] d1_num [DIV1_NW+1];
    logic [DIV1_NW-1:0] d1_quo [DIV1_NW+1];

    assign d1_rem[0] = DIV1_RW'(r_prod[29:15]);
    assign d1_num[0] = r_prod[14:0];
    assign d1_quo[0] = '0;

    for (genvar g = 0; g < DIV1_NW; g++) begin : g_div1
        ftaa_div_cell #(.RW(DIV1_RW), .NW(DIV1_NW)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (DIV1_RW'(r_slow)),
            .i_rem (d1_rem[g]),
            .i_num (d1_num[g]),
            .i_quo (d1_quo[g]),
            .o_rem (d1_rem[g+1]),
            .o_num (d1_num[g+1]),
            .o_quo (d1_quo[g+1])
        );
    end

    // ---------------- target rotation, velocity error ----------------
    t_wside             ws_end;
    logic        [14:0] tmag;
    logic signed [15:0] n_trot;

    assign ws_end = r_ws1[DIV1_NW];

    always_comb begin
        unique case (ws_end.cls)
            CLS_ZERO: tmag = 15'd0;
            CLS_MAX:  tmag = ws_end.maxa;
            CLS_RAMP: tmag = d1_quo[DIV1_NW];
            default:  tmag = 15'd0;
        endcase
        n_trot = ws_end.neg ? -16'(tmag) : 16'(tmag);
    end

    logic signed [15:0] r_trot;
    logic signed [15:0] r_tvel;
    logic        [14:0] r_tmaxa;
    logic signed [16:0] diff;
    logic        [15:0] dmag;
    logic        [15:0] r_dmag;
    t_eside             r_es [DIV2_NW+1];

    assign diff = 17'(r_trot) - 17'(r_tvel);
    assign dmag = diff[16] ? 16'(-diff) : diff[15:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trot        <= n_trot;
            r_tvel        <= ws_end.vel;
            r_tmaxa       <= ws_end.maxa;
            r_dmag        <= dmag;
            r_es[0].dneg  <= diff[16];
            r_es[0].mzero <= (dmag == 16'd0);
            // Quotient of 2^16 or more: saturate (also covers a zero divisor).
            r_es[0].ovf   <= (16'(dmag[15:4]) >= r_ttt);
            r_es[0].maxa  <= r_tmaxa;
            for (int k = 0; k < DIV2_NW; k++) begin
                r_es[k+1] <= r_es[k];
            end
        end
    end

    // ---------------- time-constant divider: |diff| * 4096 / time_to_target ----
    logic [DIV2_RW-1:0] d2_rem [DIV2_NW+1];
    logic [DIV2_NW-1:0] d2_num [DIV2_NW+1];
    logic [DIV2_NW-1:0] d2_quo [DIV2_NW+1];

    assign d2_rem[0] = DIV2_RW'(r_dmag[15:4]);
    assign d2_num[0] = {r_dmag[3:0], 12'd0};
    assign d2_quo[0] = '0;

    for (genvar g = 0; g < DIV2_NW; g++) begin : g_div2
        ftaa_div_cell #(.RW(DIV2_RW), .NW(DIV2_NW)) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_div (DIV2_RW'(r_ttt)),
            .i_rem (d2_rem[g]),
            .i_num (d2_num[g]),
            .i_quo (d2_quo[g]),
            .o_rem (d2_rem[g+1]),
            .o_num (d2_num[g+1]),
            .o_quo (d2_quo[g+1])
        );
    end

    // ---------------- saturation and output register ----------------
    t_eside             es_end;
    logic        [14:0] amag;
    logic signed [15:0] r_out;

    assign es_end = r_es[DIV2_NW];

    always_comb begin
        priority if (es_end.mzero) begin
            amag = 15'd0;
        end else if (es_end.ovf || d2_quo[DIV2_NW] > 16'(es_end.maxa)) begin
            amag = es_end.maxa;
        end else begin
            amag = d2_quo[DIV2_NW][14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= es_end.dneg ? -16'(amag) : 16'(amag);
        end
    end

    assign o_rot_accel = r_out;

endmodule

FILE: sv/ftaa_checker.sv
// Port-level checker for face_target_angular_accel, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ftaa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [15:0] i_owner_x,
    input logic [15:0] i_owner_y,
    input logic [15:0] i_target_x,
    input logic [15:0] i_target_y,
    input logic [15:0] i_facing,
    input logic [15:0] i_rot_velocity,
    input logic [14:0] i_max_rot_accel,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_rot_accel,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [3:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result holds.
    `ASSERT_RST(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rot_accel), "stalled result changed")

    // Input stalls exactly when a finished result is held back.
    `ASSERT_ALL(a_in_stall, o_in_stall == (o_out_valid && i_out_stall), "input stall mismatch")

    // Reset empties the pipeline.
    `ASSERT_ALL(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A write to slow_radius reads back.
    `ASSERT_RST(a_cfg_rb, (psel && penable && pwrite && pready && paddr == 4'd0) ##1 (paddr == 4'd0) |-> prdata[14:0] == $past(pwdata[14:0]), "register readback mismatch")

endmodule

bind face_target_angular_accel ftaa_checker u_ftaa_checker (.*);
